>>> src/ple_pkg.sv
// Shared types and codes for the positional list engine.
package ple_pkg;

    // Width of a 1-based position field
    localparam int POS_W = 7;
    // Width of one stored element
    localparam int VAL_W = 32;

    // Request codes
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_GET    = 2'd1,
        OP_DELETE = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_BAD  = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    // One request item
    typedef struct packed {
        t_op                     opcode;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] elem_value;
    } t_in_item;

    // One result item
    typedef struct packed {
        t_status                 status;
        logic signed [VAL_W-1:0] read_value;
        logic [POS_W-1:0]        length;
    } t_out_item;

    // Command broadcast from the controller to every cell
    typedef struct packed {
        logic             shift_up;
        logic             shift_dn;
        logic             rd_en;
        logic [POS_W-1:0] pos0;
        logic [VAL_W-1:0] value;
    } t_cell_cmd;

endpackage

>>> src/ple_cell.sv
// One storage cell of the element chain.
module ple_cell #(
    parameter int INDEX = 0,
    parameter int IDX_W = 6
) (
    input  logic                      i_clk,
    input  ple_pkg::t_cell_cmd        i_cmd,
    input  logic [ple_pkg::VAL_W-1:0] i_left,
    input  logic [ple_pkg::VAL_W-1:0] i_right,
    output logic [ple_pkg::VAL_W-1:0] o_val,
    output logic [ple_pkg::VAL_W-1:0] o_rd
);

    localparam int CMP_W = (IDX_W > ple_pkg::POS_W) ? IDX_W : ple_pkg::POS_W;
    localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(INDEX);

    logic [ple_pkg::VAL_W-1:0] r_val;
    logic [ple_pkg::VAL_W-1:0] n_val;
    logic [CMP_W-1:0]          pos_ext;
    logic                      at_pos;
    logic                      after_pos;

    // Locate this cell relative to the target position
    assign pos_ext   = CMP_W'(i_cmd.pos0);
    assign at_pos    = (pos_ext == MY_IDX);
    assign after_pos = (pos_ext <= MY_IDX);

    // Take the new value, the left neighbor on insert, the right one on delete
    always_comb begin
        n_val = r_val;
        if (i_cmd.shift_up && after_pos) begin
            n_val = at_pos ? i_cmd.value : i_left;
        end else if (i_cmd.shift_dn && after_pos) begin
            n_val = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    // Drive the read bus only when addressed
    assign o_val = r_val;
    assign o_rd  = (i_cmd.rd_en && at_pos) ? r_val : '0;

endmodule

>>> src/ple_ctrl.sv
// Request decode, position checks and element count for the list engine.
module ple_ctrl #(
    parameter int CAPACITY = 64,
    parameter int CNT_W    = 7
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  ple_pkg::t_in_item  i_item,
    output ple_pkg::t_cell_cmd o_cmd,
    output ple_pkg::t_status   o_status,
    output logic [CNT_W-1:0]   o_count,
    output logic [CNT_W-1:0]   o_next_count
);

    localparam int CMP_W = (CNT_W + 1 > ple_pkg::POS_W) ? CNT_W + 1 : ple_pkg::POS_W;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CMP_W-1:0] pos_x;
    logic [CMP_W-1:0] cnt_x;
    logic             ok_rd;
    logic             ok_ins;
    logic             full;
    logic             shift_up;
    logic             shift_dn;
    logic             rd_en;
    ple_pkg::t_status status;

    // Range checks against the current length
    assign pos_x  = CMP_W'(i_item.position);
    assign cnt_x  = CMP_W'(r_count);
    assign ok_rd  = (pos_x != '0) && (pos_x <= cnt_x);
    assign ok_ins = (pos_x != '0) && (pos_x <= cnt_x + CMP_W'(1));
    assign full   = (r_count == CNT_W'(CAPACITY));

    // Decode the request
    always_comb begin
        status   = ple_pkg::ST_OK;
        shift_up = 1'b0;
        shift_dn = 1'b0;
        rd_en    = 1'b0;
        n_count  = r_count;
        case (i_item.opcode)
            ple_pkg::OP_INSERT: begin
                if (!ok_ins) begin
                    status = ple_pkg::ST_BAD;
                end else if (full) begin
                    status = ple_pkg::ST_FULL;
                end else begin
                    shift_up = 1'b1;
                    n_count  = r_count + CNT_W'(1);
                end
            end
            ple_pkg::OP_GET: begin
                if (!ok_rd) begin
                    status = ple_pkg::ST_BAD;
                end else begin
                    rd_en = 1'b1;
                end
            end
            ple_pkg::OP_DELETE: begin
                if (!ok_rd) begin
                    status = ple_pkg::ST_BAD;
                end else begin
                    shift_dn = 1'b1;
                    n_count  = r_count - CNT_W'(1);
                end
            end
            ple_pkg::OP_CLEAR: begin
                n_count = '0;
            end
            default: begin
                status = ple_pkg::ST_BAD;
            end
        endcase
    end

    // Advance the count on each transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_accept) begin
            r_count <= n_count;
        end
    end

    // Broadcast the command only on a transfer
    assign o_cmd.shift_up = shift_up && i_accept;
    assign o_cmd.shift_dn = shift_dn && i_accept;
    assign o_cmd.rd_en    = rd_en && i_accept;
    assign o_cmd.pos0     = i_item.position - ple_pkg::POS_W'(1);
    assign o_cmd.value    = i_item.elem_value;
    assign o_status       = status;
    assign o_count        = r_count;
    assign o_next_count   = n_count;

endmodule

>>> src/positional_list_engine.sv
// Top level of the positional list engine: cell chain, controller, result register.
//
//  channel   | valid        | stall        | payload
//  ----------+--------------+--------------+-----------------------------
//  request   | i_in_valid   | o_in_stall   | i_in_data  (t_in_item)
//  result    | o_out_valid  | i_out_stall  | o_out_data (t_out_item)
//
// One request per cycle while the request side is not stalled; its result
// appears in the result register on the next cycle. Insert and delete move
// every cell at or after the target position at once along the chain. Reset
// clears the count and the result valid; stored words stay undefined until
// inserted. Requests stall only while a result waits and the result side stalls.
module positional_list_engine #(
    parameter int CAPACITY = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ple_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ple_pkg::t_out_item o_out_data
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);

    logic                      accept;
    ple_pkg::t_cell_cmd        cmd;
    ple_pkg::t_status          status;
    logic [CNT_W-1:0]          count;
    logic [CNT_W-1:0]          next_count;
    logic [ple_pkg::VAL_W-1:0] cell_val [CAPACITY];
    logic [ple_pkg::VAL_W-1:0] cell_rd  [CAPACITY];
    logic [ple_pkg::VAL_W-1:0] rd_word;
    logic                      r_out_valid;
    ple_pkg::t_out_item        r_out_data;

    // Take a request unless a result is held back
    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    ple_ctrl #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_item       (i_in_data),
        .o_cmd        (cmd),
        .o_status     (status),
        .o_count      (count),
        .o_next_count (next_count)
    );

    // Build the chain; end cells feed back their own word
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [ple_pkg::VAL_W-1:0] left_val;
        logic [ple_pkg::VAL_W-1:0] right_val;
        if (g == 0) begin : g_first
            assign left_val = cell_val[g];
        end else begin : g_mid_l
            assign left_val = cell_val[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign right_val = cell_val[g];
        end else begin : g_mid_r
            assign right_val = cell_val[g+1];
        end
        ple_cell #(
            .INDEX (g),
            .IDX_W (IDX_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (cmd),
            .i_left  (left_val),
            .i_right (right_val),
            .o_val   (cell_val[g]),
            .o_rd    (cell_rd[g])
        );
    end

    // Merge the masked read words
    always_comb begin
        rd_word = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            rd_word = rd_word | cell_rd[i];
        end
    end

    // Hold the result until the downstream transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data.status     <= status;
            r_out_data.read_value <= $signed(rd_word);
            r_out_data.length     <= ple_pkg::POS_W'(next_count);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Count never passes the capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        count <= CNT_W'(CAPACITY))
        else $error("element count above capacity");

    // A successful insert grows the count by one
    a_insert_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.shift_up |=> count == $past(count) + CNT_W'(1))
        else $error("insert did not grow the count");

    // A clear empties the list
    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in_data.opcode == ple_pkg::OP_CLEAR) |=> count == '0)
        else $error("clear left elements");

    // Full is reported only at capacity
    a_full_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && status == ple_pkg::ST_FULL) |-> count == CNT_W'(CAPACITY))
        else $error("full reported below capacity");

endmodule
